@@ rtl/sspi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspi_pkg
// Shared widths and the six-tap filter coefficients of the sub-pel interpolator.
// ----------------------------------------------------------------------------
package sspi_pkg;

  localparam int unsigned PIX_W = 16;
  localparam int unsigned ACC_W = 23;
  localparam int unsigned TAPS = 6;
  localparam int unsigned IN_DATA_W = 32;
  localparam int unsigned OUT_DATA_W = 136;

  typedef logic signed [PIX_W-1:0] pix_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  function automatic acc_t tap_product(input logic [2:0] tap, input pix_t smp);
    acc_t ext;
    ext = ACC_W'(smp);
    case (tap)
      3'd0, 3'd5: tap_product = ext;
      3'd1, 3'd4: tap_product = -((ext <<< 2) + ext);
      3'd2, 3'd3: tap_product = (ext <<< 4) + (ext <<< 2);
      default:    tap_product = '0;
    endcase
  endfunction

endpackage

@@ rtl/six_tap_subpel_interpolator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// six_tap_subpel_interpolator
// Window-memory based six-tap half/quarter-pel interpolator.
//
// Channel   Dir  Payload (tdata low bit up)                          tuser / tlast
// s_axis    in   sample, win_row, win_col, dir_x, dir_y, quarter,     tuser: op
//                small_block (32 bits)
// m_axis    out  pix0..pix7, out_row, out_half, zero pad (136 bits)  tlast: last
//
// A window write, or a run without a direction, is taken in ST_IDLE, which it does not leave.
// Each computed sample issues six memory reads (seven in quarter mode outside the
// diagonal first phase, for the full sample), waits in ST_WAIT and ends in ST_FIN.
// Diagonal mode first computes each of the (size+5)*size intermediates.
// The window and intermediate memories are not reset; control resets at once.
// A run holds when the output register is full and not taken.
// ----------------------------------------------------------------------------
module six_tap_subpel_interpolator #(
  parameter int unsigned BLOCK = 16,
  parameter int unsigned LANES = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // sample, win_row, win_col, dir_x, dir_y, quarter, small_block
  input  logic [sspi_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // op
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // pix0 .. pix7, out_row, out_half
  output logic [sspi_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tlast
);
  import sspi_pkg::*;

  localparam int unsigned WIN = BLOCK + 6;
  localparam int unsigned WW = $clog2(WIN);
  localparam int unsigned AW = $clog2(WIN * WIN);
  localparam int unsigned TDEPTH = BLOCK * (BLOCK + 5);
  localparam int unsigned TW = $clog2(TDEPTH);
  localparam int unsigned LW = (LANES > 1) ? $clog2(LANES) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  pix_t win_mem [WIN*WIN];
  pix_t tmp_mem [TDEPTH];

  logic [1:0]    state_q, state_d;
  logic          diag_ph_q, diag_ph_d;
  logic          mdx_q, mdy_q, hx_q, vy_q, quarter_q, small_q;
  logic [WW-1:0] rq_q, rq_d, cq_q, cq_d;
  logic [2:0]    tq_q, tq_d;
  logic          rv_q, rsrc_q;
  logic [2:0]    rt_q;
  acc_t          acc_q;
  pix_t          full_q;
  pix_t          win_rd_q, tmp_rd_q;
  pix_t          lanes_q [LANES];
  logic [LW-1:0] ln_q;
  logic          seg_q;
  logic          ovalid_q;
  logic [OUT_DATA_W-1:0] odata_q, odata_d;
  logic          olast_q;

  logic          in_acc;
  logic          in_op;
  pix_t          in_sample;
  logic [4:0]    in_row, in_col;
  logic [1:0]    in_dx, in_dy;
  logic          in_quarter, in_small;

  assign in_op      = s_axis_tuser;
  assign in_sample  = s_axis_tdata[15:0];
  assign in_row     = s_axis_tdata[20:16];
  assign in_col     = s_axis_tdata[25:21];
  assign in_dx      = s_axis_tdata[27:26];
  assign in_dy      = s_axis_tdata[29:28];
  assign in_quarter = s_axis_tdata[30];
  assign in_small   = s_axis_tdata[31];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  logic [WW-1:0] size;
  logic [2:0]    ntaps;
  assign size  = small_q ? WW'(BLOCK / 2) : WW'(BLOCK);
  assign ntaps = (!diag_ph_q && quarter_q) ? 3'd7 : 3'd6;

  // Read address generation for the tap being issued.
  logic [WW-1:0] ar, ac, trow;
  logic          use_tmp;
  logic [AW-1:0] win_ra;
  logic [TW-1:0] tmp_ra, tmp_wa;

  always_comb begin
    use_tmp = 1'b0;
    trow = rq_q + WW'(tq_q);
    ar = rq_q + WW'(3);
    ac = cq_q + WW'(3);
    if (diag_ph_q) begin
      ar = rq_q + WW'(vy_q);
      ac = cq_q + WW'(hx_q) + WW'(tq_q);
    end else if (tq_q == 3'd6) begin
      ar = rq_q + WW'(3);
      ac = cq_q + WW'(3);
    end else if (!mdy_q) begin
      ac = cq_q + WW'(hx_q) + WW'(tq_q);
    end else if (!mdx_q) begin
      ar = rq_q + WW'(vy_q) + WW'(tq_q);
    end else begin
      use_tmp = 1'b1;
    end
    win_ra = AW'(ar) * AW'(WIN) + AW'(ac);
    tmp_ra = TW'(trow) * TW'(size) + TW'(cq_q);
    tmp_wa = TW'(rq_q) * TW'(size) + TW'(cq_q);
  end

  // Finishing arithmetic.
  acc_t          rnd;
  pix_t          half, res;
  logic [16:0]   qsum;
  assign rnd  = acc_q + ACC_W'(16);
  assign half = rnd[20:5];
  assign qsum = {full_q[15], full_q} + {half[15], half} + 17'd1;
  assign res  = quarter_q ? qsum[16:1] : half;

  logic col_end, emit, stall, fin_go;
  assign col_end = (cq_q == size - WW'(1));
  assign emit    = (ln_q == LW'(LANES - 1)) || col_end;
  assign stall   = !diag_ph_q && emit && ovalid_q && !m_axis_tready;
  assign fin_go  = (state_q == ST_FIN) && !stall;

  logic phase_end;
  assign phase_end = col_end &&
                     (diag_ph_q ? (rq_q == size + WW'(4)) : (rq_q == size - WW'(1)));

  always_comb begin
    state_d   = state_q;
    diag_ph_d = diag_ph_q;
    rq_d      = rq_q;
    cq_d      = cq_q;
    tq_d      = tq_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_op && (in_dx != 2'd0 || in_dy != 2'd0)) begin
          state_d   = ST_ISSUE;
          diag_ph_d = (in_dx != 2'd0) && (in_dy != 2'd0);
          rq_d      = '0;
          cq_d      = '0;
          tq_d      = '0;
        end
      end
      ST_ISSUE: begin
        tq_d = tq_q + 3'd1;
        if (tq_q == ntaps - 3'd1) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!stall) begin
          tq_d    = '0;
          state_d = ST_ISSUE;
          if (col_end) begin
            cq_d = '0;
            rq_d = rq_q + WW'(1);
          end else begin
            cq_d = cq_q + WW'(1);
          end
          if (phase_end) begin
            rq_d = '0;
            if (diag_ph_q) begin
              diag_ph_d = 1'b0;
            end else begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      diag_ph_q <= 1'b0;
      rq_q      <= '0;
      cq_q      <= '0;
      tq_q      <= '0;
      rv_q      <= 1'b0;
      ln_q      <= '0;
      seg_q     <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      diag_ph_q <= diag_ph_d;
      rq_q      <= rq_d;
      cq_q      <= cq_d;
      tq_q      <= tq_d;
      rv_q      <= (state_q == ST_ISSUE);
      if (state_q == ST_IDLE) begin
        ln_q  <= '0;
        seg_q <= 1'b0;
      end else if (fin_go && !diag_ph_q) begin
        ln_q  <= emit ? '0 : ln_q + LW'(1);
        seg_q <= col_end ? 1'b0 : (emit ? ~seg_q : seg_q);
      end
      if (fin_go && !diag_ph_q && emit) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Payload and mode registers.
  always_ff @(posedge clk_i) begin
    if (in_acc && in_op) begin
      mdx_q     <= (in_dx != 2'd0);
      mdy_q     <= (in_dy != 2'd0);
      hx_q      <= (in_dx == 2'd1);
      vy_q      <= (in_dy == 2'd1);
      quarter_q <= in_quarter;
      small_q   <= in_small;
    end
    rt_q   <= tq_q;
    rsrc_q <= use_tmp;
    if (state_q == ST_IDLE || fin_go) begin
      acc_q <= '0;
    end else if (rv_q) begin
      if (rt_q == 3'd6) begin
        full_q <= win_rd_q;
      end else begin
        acc_q <= acc_q + tap_product(rt_q, rsrc_q ? tmp_rd_q : win_rd_q);
      end
    end
  end

  always_comb begin
    odata_d = '0;
    for (int j = 0; j < LANES; j++) begin
      odata_d[16*j +: 16] = (LW'(j) == ln_q) ? res : lanes_q[j];
    end
    odata_d[131:128] = 4'(rq_q);
    odata_d[132]     = seg_q;
  end

  // Lane buffer and output register.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      for (int j = 0; j < LANES; j++) begin
        lanes_q[j] <= '0;
      end
    end else if (fin_go && !diag_ph_q) begin
      if (emit) begin
        for (int j = 0; j < LANES; j++) begin
          lanes_q[j] <= '0;
        end
      end else begin
        lanes_q[ln_q] <= res;
      end
    end
    if (fin_go && !diag_ph_q && emit) begin
      odata_q <= odata_d;
      olast_q <= phase_end;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tlast  = olast_q;

  // Window memory.
  always_ff @(posedge clk_i) begin
    if (in_acc && !in_op && (AW'(in_row) < AW'(WIN)) && (AW'(in_col) < AW'(WIN))) begin
      win_mem[AW'(in_row) * AW'(WIN) + AW'(in_col)] <= in_sample;
    end
    win_rd_q <= win_mem[win_ra];
  end

  // Intermediate memory of the diagonal mode.
  always_ff @(posedge clk_i) begin
    if (fin_go && diag_ph_q) begin
      tmp_mem[tmp_wa] <= half;
    end
    tmp_rd_q <= tmp_mem[tmp_ra];
  end

endmodule
